// File: hdl/lesf_pkg.sv
// shared constants, types and register codes for the largest empty square finder
`timescale 1ns / 1ps
package lesf_pkg;

	// default map limits
	localparam int DEF_MAX_COLS = 1024;
	localparam int DEF_MAX_ROWS = 4096;

	// field widths
	localparam int CHAR_W      = 8;
	localparam int VAL_W       = 11;
	localparam int LEN_W       = 11;
	localparam int OUT_ROW_W   = 12;
	localparam int OUT_COL_W   = 10;
	localparam int IN_TDATA_W  = 8;
	localparam int OUT_TDATA_W = 40;

	// configuration port
	localparam int APB_DATA_W = 32;
	localparam int APB_ADDR_W = 3;

	// reset values of the configuration registers
	localparam logic [CHAR_W-1:0] OBSTACLE_RST   = 8'd111;
	localparam logic [LEN_W-1:0]  ROW_LENGTH_RST = 11'd1024;

	// saturation limit of a cell value
	localparam logic [VAL_W-1:0] VAL_MAX = '1;

	// register index codes, taken from paddr[2]
	typedef enum logic {
		REG_OBSTACLE   = 1'b0,
		REG_ROW_LENGTH = 1'b1
	} reg_idx_t;

	// configuration seen by the datapath
	typedef struct packed {
		logic [CHAR_W-1:0] obstacle_char;
		logic [LEN_W-1:0]  row_length;
	} cfg_t;

endpackage

// File: hdl/lesf_ram.sv
// generic single-port-write, single-port-read ram with registered read data
`timescale 1ns / 1ps
module lesf_ram #(
	parameter int WIDTH = 11,
	parameter int DEPTH = 1024,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read, old data on a same-address write
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

// File: hdl/lesf_apb_regs.sv
// apb configuration registers: obstacle character and row length
`timescale 1ns / 1ps
module lesf_apb_regs (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [lesf_pkg::APB_ADDR_W-1:0]  paddr,
	input  logic [lesf_pkg::APB_DATA_W-1:0]  pwdata,
	output logic [lesf_pkg::APB_DATA_W-1:0]  prdata,
	output logic                             pready,
	output lesf_pkg::cfg_t                   cfg
);
	import lesf_pkg::*;

	logic              wr_en;
	reg_idx_t          idx;
	logic [CHAR_W-1:0] obstacle_q;
	logic [LEN_W-1:0]  row_length_q;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite & pready;
	assign idx    = reg_idx_t'(paddr[2]);

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			obstacle_q   <= OBSTACLE_RST;
			row_length_q <= ROW_LENGTH_RST;
		end else if (wr_en) begin
			unique case (idx)
				REG_OBSTACLE:   obstacle_q   <= pwdata[CHAR_W-1:0];
				REG_ROW_LENGTH: row_length_q <= pwdata[LEN_W-1:0];
				default:        ;
			endcase
		end
	end

	// read mux
	always_comb begin
		unique case (idx)
			REG_OBSTACLE:   prdata = APB_DATA_W'(obstacle_q);
			REG_ROW_LENGTH: prdata = APB_DATA_W'(row_length_q);
			default:        prdata = '0;
		endcase
	end

	assign cfg.obstacle_char = obstacle_q;
	assign cfg.row_length    = row_length_q;

endmodule

// File: hdl/largest_empty_square_finder.sv
// top level: streaming maximal empty square search over a raster map
`timescale 1ns / 1ps
// Map cells stream in on the s_axis channel in raster order, one character
// per transaction, s_axis_tlast on the final cell of the map. The user must
// set row length and obstacle character over the apb port only while the
// block is idle; the block does not enforce this. Each cell's square size
// is formed from the line buffer, the left and the diagonal neighbour in the
// cycle the transaction is accepted; the running best is updated in the same
// cycle. One result leaves on the m_axis channel for each map, registered, in
// the cycle after the last cell is accepted. Throughput is one cell per cycle,
// set by the single line-buffer read issued ahead of each cell (with a bypass
// when the next cell reads the entry just written).
// While a result waits on a stalled m_axis_tready, new cells are held off;
// otherwise cells are taken every cycle, also while a result is handed over.
// Reset clears all stream state and the configuration registers; the line
// buffer is not cleared, row 0 never reads it.
module largest_empty_square_finder #(
	parameter int MAX_COLS = lesf_pkg::DEF_MAX_COLS,
	parameter int MAX_ROWS = lesf_pkg::DEF_MAX_ROWS
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// cell stream
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	input  logic [lesf_pkg::IN_TDATA_W-1:0]   s_axis_tdata,  // [7:0] cell_char
	input  logic                              s_axis_tlast,  // last_cell
	// result stream
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	// [10:0] best_size, [22:11] best_row, [32:23] best_col, [33] row_overflow
	output logic [lesf_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
	// configuration
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [lesf_pkg::APB_ADDR_W-1:0]   paddr,
	input  logic [lesf_pkg::APB_DATA_W-1:0]   pwdata,
	output logic [lesf_pkg::APB_DATA_W-1:0]   prdata,
	output logic                              pready
);
	import lesf_pkg::*;

	localparam int COL_W = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
	localparam int ROW_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
	localparam int LW    = (COL_W + 1 > LEN_W) ? COL_W + 1 : LEN_W;
	localparam logic [LW-1:0]    LEN_MAX  = LW'(MAX_COLS);
	localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(MAX_ROWS - 1);

	cfg_t cfg;

	// stream state
	logic [COL_W-1:0] col_q;
	logic [ROW_W-1:0] row_q;
	logic [VAL_W-1:0] left_q;
	logic [VAL_W-1:0] diag_q;
	logic [VAL_W-1:0] best_val_q;
	logic [ROW_W-1:0] best_row_q;
	logic [COL_W-1:0] best_col_q;
	logic             ovf_q;

	// line buffer bypass
	logic             byp_q;
	logic [VAL_W-1:0] byp_data_q;

	// result register
	logic                 out_valid_q;
	logic [VAL_W-1:0]     out_size_q;
	logic [OUT_ROW_W-1:0] out_row_q;
	logic [OUT_COL_W-1:0] out_col_q;
	logic                 out_ovf_q;

	logic             accept;
	logic [VAL_W-1:0] ram_rdata;
	logic [VAL_W-1:0] up_raw;
	logic [VAL_W-1:0] up;
	logic [VAL_W-1:0] left;
	logic [VAL_W-1:0] diag;
	logic [VAL_W-1:0] min_ul;
	logic [VAL_W-1:0] min_all;
	logic [VAL_W-1:0] val;
	logic [LW-1:0]    len;
	logic [LW-1:0]    col_inc;
	logic             row_end;
	logic [COL_W-1:0] col_nxt;
	logic [COL_W-1:0] col_upd;
	logic [ROW_W-1:0] row_upd;
	logic             ovf_upd;
	logic             better;
	logic [VAL_W-1:0] best_val_upd;
	logic [ROW_W-1:0] best_row_upd;
	logic [COL_W-1:0] best_col_upd;

	lesf_apb_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// handshake
	assign s_axis_tready = ~out_valid_q | m_axis_tready;
	assign accept        = s_axis_tvalid & s_axis_tready;

	// neighbour values, zero outside the map
	assign up_raw = byp_q ? byp_data_q : ram_rdata;
	assign up     = (row_q != '0) ? up_raw : '0;
	assign left   = (col_q != '0) ? left_q : '0;
	assign diag   = ((row_q != '0) && (col_q != '0)) ? diag_q : '0;

	// three-way minimum plus one, saturating, zero on an obstacle cell
	always_comb begin
		min_ul  = (left < up) ? left : up;
		min_all = (diag < min_ul) ? diag : min_ul;
		if (s_axis_tdata[CHAR_W-1:0] == cfg.obstacle_char) begin
			val = '0;
		end else if (min_all == VAL_MAX) begin
			val = VAL_MAX;
		end else begin
			val = min_all + VAL_W'(1);
		end
	end

	// effective row length, zero acts as one, clamped to the buffer size
	always_comb begin
		len = LW'(cfg.row_length);
		if (len == '0) begin
			len = LW'(1);
		end else if (len > LEN_MAX) begin
			len = LEN_MAX;
		end
	end

	// position advance and overflow
	always_comb begin
		col_inc = LW'(col_q) + LW'(1);
		row_end = (col_inc >= len);
		col_upd = row_end ? '0 : col_inc[COL_W-1:0];
		row_upd = row_q;
		ovf_upd = ovf_q;
		if (row_end) begin
			if (row_q == ROW_LAST) begin
				if (!s_axis_tlast) begin
					ovf_upd = 1'b1;
				end
			end else begin
				row_upd = row_q + ROW_W'(1);
			end
		end
	end

	// running best, first strictly larger value wins
	always_comb begin
		better       = (val > best_val_q);
		best_val_upd = better ? val : best_val_q;
		best_row_upd = better ? row_q : best_row_q;
		best_col_upd = better ? col_q : best_col_q;
	end

	// read address for the next cell
	always_comb begin
		if (!accept) begin
			col_nxt = col_q;
		end else if (s_axis_tlast) begin
			col_nxt = '0;
		end else begin
			col_nxt = col_upd;
		end
	end

	lesf_ram #(
		.WIDTH (VAL_W),
		.DEPTH (MAX_COLS)
	) u_line_buf (
		.clk   (clk),
		.we    (accept),
		.waddr (col_q),
		.wdata (val),
		.raddr (col_nxt),
		.rdata (ram_rdata)
	);

	// bypass when the next read hits the entry written now
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byp_q <= 1'b0;
		end else begin
			byp_q <= accept & (col_nxt == col_q);
		end
	end

	always_ff @(posedge clk) begin
		byp_data_q <= val;
	end

	// stream state update, cleared after the last cell
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q      <= '0;
			row_q      <= '0;
			left_q     <= '0;
			diag_q     <= '0;
			best_val_q <= '0;
			best_row_q <= '0;
			best_col_q <= '0;
			ovf_q      <= 1'b0;
		end else if (accept) begin
			if (s_axis_tlast) begin
				col_q      <= '0;
				row_q      <= '0;
				left_q     <= '0;
				diag_q     <= '0;
				best_val_q <= '0;
				best_row_q <= '0;
				best_col_q <= '0;
				ovf_q      <= 1'b0;
			end else begin
				col_q      <= col_upd;
				row_q      <= row_upd;
				left_q     <= val;
				diag_q     <= up;
				best_val_q <= best_val_upd;
				best_row_q <= best_row_upd;
				best_col_q <= best_col_upd;
				ovf_q      <= ovf_upd;
			end
		end
	end

	// result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept && s_axis_tlast) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (accept && s_axis_tlast) begin
			out_size_q <= best_val_upd;
			out_row_q  <= OUT_ROW_W'(best_row_upd);
			out_col_q  <= OUT_COL_W'(best_col_upd);
			out_ovf_q  <= ovf_q;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = OUT_TDATA_W'({out_ovf_q, out_col_q, out_row_q, out_size_q});

endmodule

// File: bench/tb.sv
// self-checking testbench for the largest empty square finder
`timescale 1ns / 1ps
module tb;
	import lesf_pkg::*;

	// result word as it leaves on m_axis_tdata, lowest field last
	typedef struct packed {
		logic [OUT_TDATA_W-35:0] pad;
		logic                    overflow;
		logic [OUT_COL_W-1:0]    col;
		logic [OUT_ROW_W-1:0]    row;
		logic [VAL_W-1:0]        side;
	} square_t;

	typedef struct packed {
		logic [CHAR_W-1:0] ch;
		logic              last;
	} cell_t;

	// square search predictor and store of expected squares
	class square_predictor;
		logic [CHAR_W-1:0]    obstacle;
		logic [LEN_W-1:0]     row_len;
		logic [VAL_W-1:0]     line_buf [DEF_MAX_COLS];
		logic [VAL_W-1:0]     left_val;
		logic [VAL_W-1:0]     diag_val;
		logic [OUT_COL_W-1:0] col_cnt;
		logic [OUT_ROW_W-1:0] row_cnt;
		logic [VAL_W-1:0]     best_val;
		logic [OUT_ROW_W-1:0] best_row;
		logic [OUT_COL_W-1:0] best_col;
		logic                 ovf;
		square_t              expected_squares [$];
		int unsigned          mismatches;

		function new();
			obstacle   = OBSTACLE_RST;
			row_len    = ROW_LENGTH_RST;
			mismatches = 0;
			clear_map();
		endfunction

		function void clear_map();
			left_val = '0;
			diag_val = '0;
			col_cnt  = '0;
			row_cnt  = '0;
			best_val = '0;
			best_row = '0;
			best_col = '0;
			ovf      = 1'b0;
		endfunction

		function void set_reg(reg_idx_t idx, logic [APB_DATA_W-1:0] value);
			case (idx)
				REG_OBSTACLE: begin
					obstacle = value[CHAR_W-1:0];
				end
				REG_ROW_LENGTH: begin
					row_len = value[LEN_W-1:0];
				end
			endcase
		endfunction

		function int unsigned pending();
			return expected_squares.size();
		endfunction

		// one accepted cell transaction
		function void take_cell(logic [CHAR_W-1:0] ch, logic last);
			int unsigned len, col, row, up, left, diag, val;
			square_t res;
			len = 32'(row_len);
			if (len == 0)
				len = 1;
			if (len > DEF_MAX_COLS)
				len = DEF_MAX_COLS;
			col = 32'(col_cnt);
			if (col >= DEF_MAX_COLS)
				col = DEF_MAX_COLS - 1;
			row  = 32'(row_cnt);
			up   = 0;
			left = 0;
			diag = 0;
			// neighbours outside the map count as zero
			if (row > 0) begin
				up = 32'(line_buf[col]);
				if (col > 0)
					diag = 32'(diag_val);
			end
			if (col > 0)
				left = 32'(left_val);
			if (ch == obstacle) begin
				val = 0;
			end else begin
				val = up;
				if (left < val)
					val = left;
				if (diag < val)
					val = diag;
				val = val + 1;
				if (val > 32'(VAL_MAX))
					val = 32'(VAL_MAX);
			end
			line_buf[col] = VAL_W'(val);
			left_val      = VAL_W'(val);
			diag_val      = VAL_W'(up);
			// first strictly largest in scan order wins
			if (val > 32'(best_val)) begin
				best_val = VAL_W'(val);
				best_row = OUT_ROW_W'(row);
				best_col = OUT_COL_W'(col);
			end
			// advance raster position, row count saturates
			if (col + 1 >= len) begin
				col_cnt = '0;
				if (row + 1 >= DEF_MAX_ROWS) begin
					if (!last)
						ovf = 1'b1;
					row_cnt = OUT_ROW_W'(DEF_MAX_ROWS - 1);
				end else begin
					row_cnt = OUT_ROW_W'(row + 1);
				end
			end else begin
				col_cnt = OUT_COL_W'(col + 1);
			end
			if (last) begin
				res          = '0;
				res.side     = best_val;
				res.row      = best_row;
				res.col      = best_col;
				res.overflow = ovf;
				expected_squares.push_back(res);
				clear_map();
			end
		endfunction

		task report(string msg);
			mismatches++;
			$display("tb: mismatch at %0t ns: %s", $time, msg);
		endtask

		// one accepted result transaction
		task check_square(logic [OUT_TDATA_W-1:0] data);
			square_t got, want;
			got = square_t'(data);
			if (expected_squares.size() == 0) begin
				report($sformatf("result %h with nothing expected", data));
				return;
			end
			want = expected_squares.pop_front();
			if (got.side != want.side)
				report($sformatf("best_size %0d, expected %0d", got.side, want.side));
			if (got.row != want.row)
				report($sformatf("best_row %0d, expected %0d", got.row, want.row));
			if (got.col != want.col)
				report($sformatf("best_col %0d, expected %0d", got.col, want.col));
			if (got.overflow != want.overflow)
				report($sformatf("row_overflow %0b, expected %0b", got.overflow,
					want.overflow));
		endtask
	endclass

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   s_axis_tvalid = 1'b0;
	logic                   s_axis_tready;
	logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;   // [7:0] cell_char
	logic                   s_axis_tlast = 1'b0; // last_cell
	logic                   m_axis_tvalid;
	logic                   m_axis_tready = 1'b0;
	// [10:0] best_size, [22:11] best_row, [32:23] best_col, [33] row_overflow
	logic [OUT_TDATA_W-1:0] m_axis_tdata;
	logic                   psel = 1'b0;
	logic                   penable = 1'b0;
	logic                   pwrite = 1'b0;
	logic [APB_ADDR_W-1:0]  paddr = '0;
	logic [APB_DATA_W-1:0]  pwdata = '0;
	logic [APB_DATA_W-1:0]  prdata;
	logic                   pready;

	square_predictor   squares;
	cell_t             cell_q [$];
	cell_t             next_cell;
	logic [CHAR_W-1:0] cur_obstacle = OBSTACLE_RST;
	int unsigned       burst_left = 8;
	int unsigned       gap_left = 0;
	int unsigned       stall_mode = 0;
	int unsigned       stall_tick = 0;
	int unsigned       random_cells = 0;

	largest_empty_square_finder u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tlast (s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	// cell sender: bursts of random length with random gaps
	always @(posedge clk) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
		end else begin
			if (s_axis_tvalid && s_axis_tready)
				squares.take_cell(s_axis_tdata, s_axis_tlast);
			if (!s_axis_tvalid || s_axis_tready) begin
				if (gap_left == 0 && cell_q.size() != 0) begin
					next_cell = cell_q.pop_front();
					s_axis_tdata  <= next_cell.ch;
					s_axis_tlast  <= next_cell.last;
					s_axis_tvalid <= 1'b1;
					burst_left--;
					if (burst_left == 0) begin
						burst_left = $urandom_range(1, 24);
						gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
					end
				end else begin
					s_axis_tvalid <= 1'b0;
					if (gap_left != 0)
						gap_left--;
				end
			end
		end
	end

	// result receiver with its own stall pattern
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			squares.check_square(m_axis_tdata);
		if (stall_tick == 0) begin
			stall_mode = $urandom_range(0, 3);
			stall_tick = $urandom_range(20, 200);
		end else begin
			stall_tick--;
		end
		case (stall_mode)
			0: m_axis_tready <= 1'b1;
			1: m_axis_tready <= 1'($urandom_range(0, 1));
			2: m_axis_tready <= ($urandom_range(0, 7) == 0);
			default: m_axis_tready <= (stall_tick % 32 < 8);
		endcase
	end

	// register write: setup cycle then access cycle
	task automatic apb_write(reg_idx_t idx, logic [APB_DATA_W-1:0] value);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		squares.set_reg(idx, value);
		if (idx == REG_OBSTACLE)
			cur_obstacle = value[CHAR_W-1:0];
	endtask

	task automatic push_cell(logic [CHAR_W-1:0] ch, logic last);
		cell_q.push_back('{ch: ch, last: last});
	endtask

	function automatic logic [CHAR_W-1:0] free_char();
		logic [CHAR_W-1:0] ch;
		ch = CHAR_W'($urandom_range(0, 255));
		while (ch == cur_obstacle)
			ch = CHAR_W'($urandom_range(0, 255));
		return ch;
	endfunction

	// one map of len x rows cells, optionally ended early
	task automatic add_map(int unsigned len, int unsigned rows, int unsigned density, bit cut);
		int unsigned cells, stop;
		logic [CHAR_W-1:0] ch;
		cells = len * rows;
		stop  = cut ? $urandom_range(1, cells) : cells;
		for (int unsigned i = 0; i < stop; i++) begin
			if ($urandom_range(1, 100) <= density)
				ch = cur_obstacle;
			else
				ch = free_char();
			push_cell(ch, i == stop - 1);
		end
		random_cells += stop;
	endtask

	// hold off until the block has handed over every expected square
	task automatic drain();
		int unsigned guard;
		guard = 0;
		while ((cell_q.size() != 0 || s_axis_tvalid || squares.pending() != 0)
				&& guard < 200000) begin
			@(negedge clk);
			guard++;
		end
		if (squares.pending() != 0)
			squares.report($sformatf("%0d squares never arrived", squares.pending()));
		repeat (4) @(posedge clk);
	endtask

	initial begin
		int unsigned len_reg, len_eff, maps, rows;
		int unsigned density_pick [6] = '{0, 5, 20, 40, 70, 100};
		logic [CHAR_W-1:0] obst;
		squares = new();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: reset configuration, single-cell maps
		push_cell(8'd111, 1'b1);
		push_cell(8'h00, 1'b1);
		push_cell(8'hFF, 1'b1);
		drain();
		apb_write(REG_OBSTACLE, 32'h00);
		apb_write(REG_ROW_LENGTH, 32'd3);
		// fully empty 3x3 map
		repeat (9) push_cell(8'hFF, 1'b0);
		cell_q[$].last = 1'b1;
		// no empty cell at all
		repeat (6) push_cell(8'h00, 1'b0);
		cell_q[$].last = 1'b1;
		// map ended in mid-row, ties keep the first cell
		push_cell(8'h01, 1'b0);
		push_cell(8'h80, 1'b0);
		push_cell(8'h7F, 1'b0);
		push_cell(8'h01, 1'b1);
		drain();
		// row length zero acts as one
		apb_write(REG_OBSTACLE, 32'hFF);
		apb_write(REG_ROW_LENGTH, 32'd0);
		push_cell(8'hFF, 1'b0);
		push_cell(8'h00, 1'b0);
		push_cell(8'h00, 1'b1);
		drain();

		// random phases of small maps
		while (random_cells < 1050) begin
			case ($urandom_range(0, 5))
				0: obst = 8'h00;
				1: obst = 8'hFF;
				2: obst = OBSTACLE_RST;
				default: obst = CHAR_W'($urandom_range(0, 255));
			endcase
			case ($urandom_range(0, 7))
				0: len_reg = 0;
				1: len_reg = 1;
				2: len_reg = $urandom_range(13, 40);
				default: len_reg = $urandom_range(2, 12);
			endcase
			len_eff = (len_reg == 0) ? 1 : len_reg;
			if ($urandom_range(0, 1)) begin
				apb_write(REG_OBSTACLE, 32'(obst));
				apb_write(REG_ROW_LENGTH, len_reg);
			end else begin
				apb_write(REG_ROW_LENGTH, len_reg);
				apb_write(REG_OBSTACLE, 32'(obst));
			end
			maps = $urandom_range(2, 6);
			for (int unsigned m = 0; m < maps; m++) begin
				rows = (len_eff < 3) ? $urandom_range(1, 20) : $urandom_range(1, 8);
				add_map(len_eff, rows, density_pick[$urandom_range(0, 5)],
					$urandom_range(0, 5) == 0);
			end
			drain();
		end
		repeat (16) @(posedge clk);

		if (squares.mismatches == 0)
			$display("tb: clean");
		else
			$display("tb: errors");
		$finish;
	end

	// watchdog
	initial begin
		#2000000;
		$display("tb: errors");
		$finish;
	end

endmodule

// File: largest_empty_square_finder.f
hdl/lesf_pkg.sv
hdl/lesf_ram.sv
hdl/lesf_apb_regs.sv
hdl/largest_empty_square_finder.sv
bench/tb.sv
